// ===== sv/gtq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the grid terrain height query block
package gtq_pkg;

  // default grid capacity
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;

  // configuration register reset values
  localparam logic [6:0]  COLUMNS_RST = 7'd10;
  localparam logic [6:0]  ROWS_RST    = 7'd10;
  localparam logic [24:0] CELL_W_RST  = 25'd65536;
  localparam logic [24:0] CELL_D_RST  = 25'd65536;

  // item operation codes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_COLUMNS    = 2'd0,
    REG_ROWS       = 2'd1,
    REG_CELL_WIDTH = 2'd2,
    REG_CELL_DEPTH = 2'd3
  } cfg_reg_t;

  // result status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_OUTSIDE = 1'b1;

  // input transaction payload
  typedef struct packed {
    op_t                opcode;
    logic [12:0]        vertex_index;
    logic signed [31:0] height_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_z;
  } query_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [31:0] surface_height;
    logic               status;
  } query_result_t;

endpackage

// ===== sv/gtq_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module gtq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gtq_udiv.sv =====
`timescale 1ns / 1ps
// pipelined restoring unsigned divider, one quotient bit per stage
module gtq_udiv #(
  parameter int NUM_W  = 33,
  parameter int DEN_W  = 26,
  parameter int Q_W    = 7,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              vld  [Q_W];
  logic [W-1:0]      part [Q_W];
  logic [Q_W-1:0]    qacc [Q_W];
  logic [SIDE_W-1:0] side [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int SH = Q_W - 1 - k;
    logic              v_in;
    logic [W-1:0]      p_in;
    logic [Q_W-1:0]    q_in;
    logic [SIDE_W-1:0] s_in;
    logic [W-1:0]      trial;
    logic              ge;

    // stage inputs come from the ports or from the previous stage
    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign p_in = W'(num);
      assign q_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign p_in = part[k-1];
      assign q_in = qacc[k-1];
      assign s_in = side[k-1];
    end

    // compare against the shifted divisor
    assign trial = W'(den) << SH;
    assign ge    = (p_in >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      part[k] <= ge ? (p_in - trial) : p_in;
      qacc[k] <= (q_in << 1) | Q_W'(ge);
      side[k] <= s_in;
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot      = qacc[Q_W-1];
  assign rem       = DEN_W'(part[Q_W-1]);
  assign side_out  = side[Q_W-1];

endmodule

// ===== sv/grid_terrain_height_query.sv =====
`timescale 1ns / 1ps
// grid terrain height query top level
//
// Holds vertex heights of a grid centred on the origin and answers the
// plane height of the grid triangle under a ground position.
// Input channel: an item is taken at a clock edge with start high and busy
// low. busy is low except in reset, so one transaction enters every cycle.
// Write items store a vertex height; query items return the interpolated
// height, or status outside with height zero.
// Result channel: done marks one result cycle per item, in item order, and
// the result is taken while done is high. The receiver cannot hold off, so
// results are never held and the pipeline never stops.
// Throughput is one item per cycle; the pipeline holds the two pipelined
// dividers: 7 stages for the cell index and 35 for the interpolation terms,
// plus 8 further register stages.
// Configuration: wr_en, wr_index, wr_data write a register, allowed only
// while no item is in flight.
// Reset clears the pipeline valid bits and loads the register defaults;
// vertex heights are undefined until written.
module grid_terrain_height_query
  import gtq_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  query_item_t   item,
  output logic          done,
  output query_result_t result,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [24:0]   wr_data
);

  localparam int DEPTH  = (MAX_COLUMNS + 1) * (MAX_ROWS + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [6:0]  grid_columns;
  logic [6:0]  grid_rows;
  logic [24:0] cell_width;
  logic [24:0] cell_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= COLUMNS_RST;
      grid_rows    <= ROWS_RST;
      cell_width   <= CELL_W_RST;
      cell_depth   <= CELL_D_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_COLUMNS:    grid_columns <= wr_data[6:0];
        REG_ROWS:       grid_rows    <= wr_data[6:0];
        REG_CELL_WIDTH: cell_width   <= wr_data;
        REG_CELL_DEPTH: cell_depth   <= wr_data;
        default: ;
      endcase
    end
  end

  // derived grid constants
  logic [6:0]  cols_clamp;
  logic [6:0]  rows_clamp;
  logic [6:0]  cols_eff;
  logic [6:0]  rows_eff;
  logic [31:0] cw;
  logic [31:0] rd;
  logic        empty;

  always_comb begin
    cols_clamp = (32'(grid_columns) > MAX_COLUMNS) ? 7'(MAX_COLUMNS) : grid_columns;
    rows_clamp = (32'(grid_rows) > MAX_ROWS) ? 7'(MAX_ROWS) : grid_rows;
  end

  always_ff @(posedge clk) begin
    cols_eff <= cols_clamp;
    rows_eff <= rows_clamp;
    cw       <= 32'(cols_clamp) * 32'(cell_width);
    rd       <= 32'(rows_clamp) * 32'(cell_depth);
    empty    <= (cols_clamp == '0) || (rows_clamp == '0) ||
                (cell_width == '0) || (cell_depth == '0);
  end

  assign busy = rst;

  // input register
  logic        s1_v;
  query_item_t s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= item;
  end

  // doubled coordinates from the grid corner and range check
  logic signed [34:0] qx_e, qz_e, ux2, uz2, lim_x, lim_z;
  logic               out_any;

  always_comb begin
    qx_e    = {{3{s1_item.query_x[31]}}, s1_item.query_x};
    qz_e    = {{3{s1_item.query_z[31]}}, s1_item.query_z};
    ux2     = (qx_e <<< 1) + $signed({3'b000, cw});
    uz2     = $signed({3'b000, rd}) - (qz_e <<< 1);
    lim_x   = $signed({2'b00, cw, 1'b0});
    lim_z   = $signed({2'b00, rd, 1'b0});
    out_any = empty || ux2[34] || (ux2 >= lim_x) || uz2[34] || (uz2 >= lim_z);
  end

  logic        s2_v;
  logic [32:0] s2_nx, s2_nz;
  op_t         s2_op;
  logic        s2_out;
  logic [12:0] s2_vidx;
  logic [31:0] s2_hval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_nx   <= out_any ? '0 : ux2[32:0];
    s2_nz   <= out_any ? '0 : uz2[32:0];
    s2_op   <= s1_item.opcode;
    s2_out  <= out_any;
    s2_vidx <= s1_item.vertex_index;
    s2_hval <= s1_item.height_value;
  end

  // cell index by division of the doubled offsets
  logic        d1x_v, d1z_v;
  logic [6:0]  d1x_q, d1z_q;
  logic [25:0] d1x_rem, d1z_rem;
  logic [14:0] d1x_side;
  logic [31:0] d1z_side;
  op_t         d1_op;
  logic        d1x_out;
  logic [12:0] d1_vidx;

  gtq_udiv #(.NUM_W(33), .DEN_W(26), .Q_W(7), .SIDE_W(15)) u_div_cx (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_v),
    .num      (s2_nx),
    .den      ({cell_width, 1'b0}),
    .side_in  ({s2_op, s2_out, s2_vidx}),
    .out_valid(d1x_v),
    .quot     (d1x_q),
    .rem      (d1x_rem),
    .side_out (d1x_side)
  );

  gtq_udiv #(.NUM_W(33), .DEN_W(26), .Q_W(7), .SIDE_W(32)) u_div_cz (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_v),
    .num      (s2_nz),
    .den      ({cell_depth, 1'b0}),
    .side_in  (s2_hval),
    .out_valid(d1z_v),
    .quot     (d1z_q),
    .rem      (d1z_rem),
    .side_out (d1z_side)
  );

  assign d1_op   = op_t'(d1x_side[14]);
  assign d1x_out = d1x_side[13];
  assign d1_vidx = d1x_side[12:0];

  // vertex base address and diagonal side products
  logic [7:0]  stride;
  logic        sa_v;
  op_t         sa_op;
  logic        sa_out;
  logic [12:0] sa_vidx;
  logic [31:0] sa_hval;
  logic [14:0] sa_base;
  logic [25:0] sa_lx2, sa_lz2;
  logic [50:0] sa_p1, sa_p2;

  assign stride = {1'b0, cols_eff} + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_v <= 1'b0;
    end else begin
      sa_v <= d1x_v;
    end
  end

  always_ff @(posedge clk) begin
    sa_op   <= d1_op;
    sa_out  <= d1x_out;
    sa_vidx <= d1_vidx;
    sa_hval <= d1z_side;
    sa_base <= 15'(d1z_q) * 15'(stride) + 15'(d1x_q);
    sa_lx2  <= d1x_rem;
    sa_lz2  <= d1z_rem;
    sa_p1   <= 51'(cell_width) * 51'(d1z_rem);
    sa_p2   <= 51'(cell_depth) * 51'(d1x_rem);
  end

  // height store, one copy per corner read
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] a00, a10, a01, a11;
  logic [31:0]       r00, r10, r01, r11;

  always_comb begin
    ram_we    = sa_v && (sa_op == OP_WRITE) && (32'(sa_vidx) < DEPTH);
    ram_waddr = ADDR_W'(sa_vidx);
    a00       = ADDR_W'(sa_base);
    a10       = ADDR_W'(sa_base + 15'd1);
    a01       = ADDR_W'(sa_base + 15'(stride));
    a11       = ADDR_W'(sa_base + 15'(stride) + 15'd1);
  end

  gtq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_00 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(sa_hval), .raddr(a00), .rdata(r00)
  );
  gtq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_10 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(sa_hval), .raddr(a10), .rdata(r10)
  );
  gtq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_01 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(sa_hval), .raddr(a01), .rdata(r01)
  );
  gtq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_11 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(sa_hval), .raddr(a11), .rdata(r11)
  );

  // triangle select alongside the ram read
  logic        sb_v;
  op_t         sb_op;
  logic        sb_out;
  logic        sb_sel;
  logic [25:0] sb_lx2, sb_lz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= 1'b0;
    end else begin
      sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    sb_op  <= sa_op;
    sb_out <= sa_out;
    sb_sel <= sa_p1 > sa_p2;
    sb_lx2 <= sa_lx2;
    sb_lz2 <= sa_lz2;
  end

  // plane slopes of the chosen triangle
  logic signed [32:0] h00e, h10e, h01e, h11e, dx_c, dz_c;

  always_comb begin
    h00e = {r00[31], r00};
    h10e = {r10[31], r10};
    h01e = {r01[31], r01};
    h11e = {r11[31], r11};
    if (sb_sel) begin
      dx_c = h11e - h01e;
      dz_c = h01e - h00e;
    end else begin
      dx_c = h10e - h00e;
      dz_c = h11e - h10e;
    end
  end

  logic               sc_v;
  op_t                sc_op;
  logic               sc_out;
  logic signed [32:0] sc_dx, sc_dz;
  logic [31:0]        sc_h00;
  logic [25:0]        sc_lx2, sc_lz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v <= 1'b0;
    end else begin
      sc_v <= sb_v;
    end
  end

  always_ff @(posedge clk) begin
    sc_op  <= sb_op;
    sc_out <= sb_out;
    sc_dx  <= dx_c;
    sc_dz  <= dz_c;
    sc_h00 <= r00;
    sc_lx2 <= sb_lx2;
    sc_lz2 <= sb_lz2;
  end

  // slope times offset
  logic               sd_v;
  op_t                sd_op;
  logic               sd_out;
  logic signed [59:0] sd_mx, sd_mz;
  logic [31:0]        sd_h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v <= 1'b0;
    end else begin
      sd_v <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    sd_op  <= sc_op;
    sd_out <= sc_out;
    sd_mx  <= sc_dx * $signed({1'b0, sc_lx2});
    sd_mz  <= sc_dz * $signed({1'b0, sc_lz2});
    sd_h00 <= sc_h00;
  end

  // round to nearest as a floor division, sign folded out
  // twice the product plus the doubled cell size, over four cell sizes
  logic [26:0]        den4x, den4z;
  logic signed [61:0] nx, nz;
  logic [61:0]        mx_mag, mz_mag;

  always_comb begin
    den4x  = {cell_width, 2'b00};
    den4z  = {cell_depth, 2'b00};
    nx     = $signed({sd_mx[59], sd_mx, 1'b0}) + $signed({36'd0, cell_width, 1'b0});
    nz     = $signed({sd_mz[59], sd_mz, 1'b0}) + $signed({36'd0, cell_depth, 1'b0});
    mx_mag = nx[61] ? (62'(-nx) + 62'(den4x) - 62'd1) : 62'(nx);
    mz_mag = nz[61] ? (62'(-nz) + 62'(den4z) - 62'd1) : 62'(nz);
  end

  logic        se_v;
  op_t         se_op;
  logic        se_out;
  logic [61:0] se_mx, se_mz;
  logic        se_negx, se_negz;
  logic [31:0] se_h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_v <= 1'b0;
    end else begin
      se_v <= sd_v;
    end
  end

  always_ff @(posedge clk) begin
    se_op   <= sd_op;
    se_out  <= sd_out;
    se_mx   <= mx_mag;
    se_mz   <= mz_mag;
    se_negx <= nx[61];
    se_negz <= nz[61];
    se_h00  <= sd_h00;
  end

  // interpolation term division
  logic        d2x_v, d2z_v;
  logic [34:0] d2x_q, d2z_q;
  logic [34:0] d2x_side;
  logic        d2z_side;
  op_t         d2_op;
  logic        d2_out;
  logic        d2_negx;
  logic [31:0] d2_h00;

  gtq_udiv #(.NUM_W(62), .DEN_W(27), .Q_W(35), .SIDE_W(35)) u_div_tx (
    .clk      (clk),
    .rst      (rst),
    .in_valid (se_v),
    .num      (se_mx),
    .den      (den4x),
    .side_in  ({se_op, se_out, se_negx, se_h00}),
    .out_valid(d2x_v),
    .quot     (d2x_q),
    .rem      (),
    .side_out (d2x_side)
  );

  gtq_udiv #(.NUM_W(62), .DEN_W(27), .Q_W(35), .SIDE_W(1)) u_div_tz (
    .clk      (clk),
    .rst      (rst),
    .in_valid (se_v),
    .num      (se_mz),
    .den      (den4z),
    .side_in  (se_negz),
    .out_valid(d2z_v),
    .quot     (d2z_q),
    .rem      (),
    .side_out (d2z_side)
  );

  assign d2_op   = op_t'(d2x_side[34]);
  assign d2_out  = d2x_side[33];
  assign d2_negx = d2x_side[32];
  assign d2_h00  = d2x_side[31:0];

  // final sum with saturation
  logic signed [36:0] tx, tz, hsum;
  logic signed [31:0] hsat;

  always_comb begin
    tx   = d2_negx ? -$signed({2'b00, d2x_q}) : $signed({2'b00, d2x_q});
    tz   = d2z_side ? -$signed({2'b00, d2z_q}) : $signed({2'b00, d2z_q});
    hsum = $signed({{5{d2_h00[31]}}, d2_h00}) + tx + tz;
    if (hsum > 37'sd2147483647) begin
      hsat = 32'sh7fffffff;
    end else if (hsum < -37'sd2147483648) begin
      hsat = 32'sh80000000;
    end else begin
      hsat = hsum[31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2x_v;
    end
  end

  always_ff @(posedge clk) begin
    if (d2_op == OP_QUERY && !d2_out) begin
      result.surface_height <= hsat;
    end else begin
      result.surface_height <= '0;
    end
    result.status <= (d2_op == OP_QUERY && d2_out) ? STATUS_OUTSIDE : STATUS_DONE;
  end

`ifndef SYNTHESIS
  // paired dividers stay in step
  a_div_pair: assert property (@(posedge clk) disable iff (rst)
    (d1x_v == d1z_v) && (d2x_v == d2z_v))
    else $error("divider valid bits out of step");

  // an inside point lands in a real cell
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (d1x_v && !d1x_out) |-> ((d1x_q < cols_eff) && (d1z_q < rows_eff)))
    else $error("cell index beyond grid");

  // offset within the cell
  a_cell_offset: assert property (@(posedge clk) disable iff (rst)
    (d1x_v && !d1x_out) |-> (d1x_rem < {cell_width, 1'b0}))
    else $error("cell offset not below cell width");

  // an outside answer carries zero height
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_OUTSIDE)) |-> (result.surface_height == '0))
    else $error("outside result with nonzero height");

  // every result follows its transaction by the pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##50 done)
    else $error("result strobe missing");
`endif

endmodule
